>>> sv/olist_pkg.sv
// Shared types and codes for the ordered list engine.
package olist_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_LOCATE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_READ,
        CELL_LOCATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [7:0]  pos_idx;
        logic [31:0] value;
    } cell_cmd_t;

    typedef struct packed {
        kind_t      kind;
        status_t    status;
        logic [7:0] length;
    } meta_t;

    localparam int WORD_W   = 32;
    localparam int GROUP_SZ = 16;

endpackage

>>> sv/ordered_list_engine.sv
// Top level of the ordered list engine: request decode, cell row, search tree and result register.
//
//  Channel  Direction  tdata (low bit up)                              tuser
//  s_       in         position[7:0], value[31:0]                      kind[1:0]
//  m_       out        status, read_value, found_position, list_length  -
//
//  The compare in every cell is registered at the edge that accepts a transaction, then
//  the group search is registered, and the final pick is loaded into the output register
//  as soon as that register is free or its result is taken.
//  A new transaction is taken only when no earlier one is still in that search path.
//  Reset empties the list by clearing the count; stored entries are not cleared.
//  A waiting result is held in the output register, and one further transaction
//  may be accepted and processed meanwhile; it then waits at the last search stage.
module ordered_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[1:0], read_value[31:0], found_position[7:0],
                                   // list_length[7:0], zero fill
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW   = IW + 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > 9) ? CW + 1 : 9;
    localparam int GS   = (CAPACITY < olist_pkg::GROUP_SZ) ? CAPACITY : olist_pkg::GROUP_SZ;
    localparam int GIW  = $clog2(GS);
    localparam int NG   = (CAPACITY + GS - 1) / GS;

    logic                 acc;
    olist_pkg::kind_t     in_kind;
    logic [7:0]           in_position;
    logic [31:0]          in_value;

    logic [CW-1:0]        count_reg, count_next;
    logic                 p1_v_reg, p1_v_next;
    logic                 p2_v_reg, p2_v_next;
    olist_pkg::meta_t     p1_meta_reg, p2_meta_reg, meta_new;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [55:0]          m_tdata_reg, m_tdata_next;
    logic                 out_load;

    olist_pkg::status_t   status_new;
    olist_pkg::cell_op_t  op_new;
    olist_pkg::cell_cmd_t cmd;
    logic [CMPW-1:0]      pos_c, cnt_c;

    logic [CAPACITY-1:0][olist_pkg::WORD_W-1:0] cell_data;
    logic [CAPACITY-1:0]                         cell_hit;

    logic [NG-1:0]                               grp_any;
    logic [NG-1:0][GIW-1:0]                      grp_idx;
    logic [NG-1:0][olist_pkg::WORD_W-1:0]        grp_data;

    logic                 sel_any;
    logic [IW-1:0]        sel_idx;
    logic [31:0]          sel_data;
    logic [FW-1:0]        found_full;
    logic [31:0]          read_value;
    logic [7:0]           found_position;

    assign in_kind     = olist_pkg::kind_t'(s_tuser);
    assign in_position = s_tdata[7:0];
    assign in_value    = s_tdata[39:8];

    assign s_tready = !p1_v_reg && !p2_v_reg;
    assign acc      = s_tvalid && s_tready;

    assign pos_c = CMPW'(in_position);
    assign cnt_c = CMPW'(count_reg);

    always_comb begin
        status_new = olist_pkg::ST_OK;
        op_new     = olist_pkg::CELL_HOLD;
        count_next = count_reg;
        if (acc) begin
            unique case (in_kind)
                olist_pkg::KIND_INSERT: begin
                    if (pos_c == '0 || pos_c > cnt_c + CMPW'(1)) begin
                        status_new = olist_pkg::ST_RANGE;
                    end else if (cnt_c == CMPW'(CAPACITY)) begin
                        status_new = olist_pkg::ST_FULL;
                    end else begin
                        op_new     = olist_pkg::CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                olist_pkg::KIND_DELETE: begin
                    if (pos_c == '0 || pos_c > cnt_c) begin
                        status_new = olist_pkg::ST_RANGE;
                    end else begin
                        op_new     = olist_pkg::CELL_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                olist_pkg::KIND_READ: begin
                    if (pos_c == '0 || pos_c > cnt_c) begin
                        status_new = olist_pkg::ST_RANGE;
                    end else begin
                        op_new = olist_pkg::CELL_READ;
                    end
                end
                olist_pkg::KIND_LOCATE: begin
                    op_new = olist_pkg::CELL_LOCATE;
                end
            endcase
        end
    end

    assign cmd.op      = op_new;
    assign cmd.pos_idx = in_position - 8'd1;
    assign cmd.value   = in_value;

    assign meta_new.kind   = in_kind;
    assign meta_new.status = status_new;
    assign meta_new.length = 8'(count_next);

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic [olist_pkg::WORD_W-1:0] left_d, right_d;
        if (j == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[j+1];
        end
        olist_cell #(
            .IDX   (j),
            .CNT_W (CW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[j]),
            .hit        (cell_hit[j])
        );
    end

    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GS;
        localparam int SZ = (CAPACITY - LO < GS) ? CAPACITY - LO : GS;
        olist_group #(
            .GW   (SZ),
            .IDXW (GIW)
        ) u_grp (
            .aclk     (aclk),
            .load     (p1_v_reg),
            .hit      (cell_hit[LO +: SZ]),
            .data     (cell_data[LO +: SZ]),
            .any      (grp_any[g]),
            .idx      (grp_idx[g]),
            .sel_data (grp_data[g])
        );
    end

    always_comb begin
        sel_any  = 1'b0;
        sel_idx  = '0;
        sel_data = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                sel_any  = 1'b1;
                sel_idx  = IW'(g * GS) + IW'(grp_idx[g]);
                sel_data = grp_data[g];
            end
        end
    end

    assign found_full = FW'(sel_idx) + FW'(1);

    assign read_value = (p2_meta_reg.kind == olist_pkg::KIND_READ &&
                         p2_meta_reg.status == olist_pkg::ST_OK) ? sel_data : '0;
    assign found_position = (p2_meta_reg.kind == olist_pkg::KIND_LOCATE && sel_any)
                            ? 8'(found_full) : 8'd0;

    assign out_load = p2_v_reg && (!m_tvalid_reg || m_tready);

    always_comb begin
        p1_v_next = acc;
        p2_v_next = p2_v_reg;
        if (p1_v_reg) begin
            p2_v_next = 1'b1;
        end else if (out_load) begin
            p2_v_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, p2_meta_reg.length, found_position, read_value,
                             p2_meta_reg.status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            p1_v_reg     <= p1_v_next;
            p2_v_reg     <= p2_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_meta_reg <= meta_new;
        end
        if (p1_v_reg) begin
            p2_meta_reg <= p1_meta_reg;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/olist_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors and flags hits.
module olist_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                      aclk,
    input  olist_pkg::cell_cmd_t      cmd,
    input  logic [CNT_W-1:0]          count,
    input  logic [olist_pkg::WORD_W-1:0] left_data,
    input  logic [olist_pkg::WORD_W-1:0] right_data,
    output logic [olist_pkg::WORD_W-1:0] data,
    output logic                      hit
);

    logic [olist_pkg::WORD_W-1:0] entry_reg, entry_next;
    logic                         hit_reg, hit_next;
    int                           pos;

    assign pos = int'(cmd.pos_idx);

    always_comb begin
        entry_next = entry_reg;
        hit_next   = 1'b0;
        unique case (cmd.op)
            olist_pkg::CELL_INSERT: begin
                if (IDX == pos) begin
                    entry_next = cmd.value;
                end else if (IDX > pos) begin
                    entry_next = left_data;
                end
            end
            olist_pkg::CELL_DELETE: begin
                if (IDX >= pos) begin
                    entry_next = right_data;
                end
            end
            olist_pkg::CELL_READ: begin
                hit_next = (IDX == pos);
            end
            olist_pkg::CELL_LOCATE: begin
                hit_next = (IDX < int'(count)) && (entry_reg == cmd.value);
            end
            default: begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign data = entry_reg;
    assign hit  = hit_reg;

endmodule

>>> sv/olist_group.sv
// Registered first-hit search and data pick over one group of cells.
module olist_group #(
    parameter int GW   = 16,
    parameter int IDXW = 4
) (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic [GW-1:0]                         hit,
    input  logic [GW-1:0][olist_pkg::WORD_W-1:0]  data,
    output logic                                  any,
    output logic [IDXW-1:0]                       idx,
    output logic [olist_pkg::WORD_W-1:0]          sel_data
);

    logic                         any_reg, any_next;
    logic [IDXW-1:0]              idx_reg, idx_next;
    logic [olist_pkg::WORD_W-1:0] data_reg, data_next;

    always_comb begin
        any_next  = 1'b0;
        idx_next  = '0;
        data_next = '0;
        for (int i = GW - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_next  = 1'b1;
                idx_next  = IDXW'(i);
                data_next = data[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            any_reg  <= any_next;
            idx_reg  <= idx_next;
            data_reg <= data_next;
        end
    end

    assign any      = any_reg;
    assign idx      = idx_reg;
    assign sel_data = data_reg;

endmodule

>>> sv/olist_checker.sv
// Port-level checker for the ordered list engine and its bind statement.
module olist_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result changed while stalled.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == olist_pkg::ST_OK ||
                      m_tdata[1:0] == olist_pkg::ST_RANGE ||
                      m_tdata[1:0] == olist_pkg::ST_FULL))
        else $error("Unknown status code.");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != olist_pkg::ST_OK |-> m_tdata[41:2] == '0)
        else $error("Failed transaction carries a read value or a found position.");

    a_one_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:2] == '0 || m_tdata[41:34] == '0))
        else $error("Read value and found position both set.");

    a_pacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while a transaction is still searching.");

endmodule

bind ordered_list_engine olist_checker u_olist_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench that streams list requests into the engine and checks every result.
module tb_top;

    localparam int CAPACITY = 128;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        olist_pkg::kind_t kind;
        logic [7:0]       position;
        logic [31:0]      value;
        int               gap;
        bit               drain;
    } list_request_t;

    typedef struct {
        olist_pkg::status_t status;
        logic [31:0]        read_value;
        logic [7:0]         found_position;
        logic [7:0]         list_length;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // position[7:0], value[31:0]
    logic [1:0]  s_tuser = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // status[1:0], read_value[31:0], found_position[7:0],
                                 // list_length[7:0], zero fill

    list_request_t request_q[$];
    list_result_t  pending_results[$];
    list_result_t  want;

    logic [31:0] list_words[CAPACITY];
    int          list_len = 0;
    int          gen_len = 0;
    int          total_items = 0;
    int          sent_cnt = 0;
    int          results_seen = 0;
    int          error_cnt = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          hold_cnt = 0;
    int          cycle_cnt = 0;

    ordered_list_engine #(.CAPACITY(CAPACITY)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic list_result_t list_apply(list_request_t req);
        list_result_t res;
        int p;
        res.status = olist_pkg::ST_OK;
        res.read_value = '0;
        res.found_position = '0;
        p = req.position;
        case (req.kind)
            olist_pkg::KIND_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    res.status = olist_pkg::ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = olist_pkg::ST_FULL;
                end else begin
                    for (int j = list_len; j >= p; j--) list_words[j] = list_words[j - 1];
                    list_words[p - 1] = req.value;
                    list_len++;
                end
            end
            olist_pkg::KIND_DELETE: begin
                if (p < 1 || p > list_len) begin
                    res.status = olist_pkg::ST_RANGE;
                end else begin
                    for (int j = p - 1; j + 1 < list_len; j++) list_words[j] = list_words[j + 1];
                    list_len--;
                end
            end
            olist_pkg::KIND_READ: begin
                if (p < 1 || p > list_len) res.status = olist_pkg::ST_RANGE;
                else res.read_value = list_words[p - 1];
            end
            default: begin
                for (int j = 0; j < list_len; j++) begin
                    if (list_words[j] == req.value) begin
                        res.found_position = 8'(j + 1);
                        break;
                    end
                end
            end
        endcase
        res.list_length = 8'(list_len);
        return res;
    endfunction

    // Items 130 to 209 and every third run of fifty go out back to back.
    function automatic int pace_gap(int idx);
        if ((idx >= 130 && idx < 210) || (idx / 50) % 3 == 1) return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic queue_request(olist_pkg::kind_t k, int pos, logic [31:0] v,
                                 bit drain = 1'b0);
        list_request_t req;
        req.kind = k;
        req.position = 8'(pos);
        req.value = v;
        req.gap = pace_gap(request_q.size());
        req.drain = drain;
        request_q.push_back(req);
        if (k == olist_pkg::KIND_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
            gen_len++;
        else if (k == olist_pkg::KIND_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    task automatic random_request(int ins_pct, int del_pct, bit drain = 1'b0);
        olist_pkg::kind_t k;
        int r;
        int pos;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < ins_pct) k = olist_pkg::KIND_INSERT;
        else if (r < ins_pct + del_pct) k = olist_pkg::KIND_DELETE;
        else if (r < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) k = olist_pkg::KIND_READ;
        else k = olist_pkg::KIND_LOCATE;
        if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 255);
        else if (k == olist_pkg::KIND_INSERT) pos = $urandom_range(1, gen_len + 1);
        else if (gen_len > 0) pos = $urandom_range(1, gen_len);
        else pos = 0;
        // A small pool of values makes duplicates and locate hits common.
        if ($urandom_range(0, 1) == 0) v = 32'($urandom_range(0, 15));
        else v = $urandom();
        queue_request(k, pos, v, drain);
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, expected, actual);
            error_cnt++;
        end
    endtask

    // Driver: one request transaction per queue entry, after its drawn gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(list_apply(request_q[0]));
                void'(request_q.pop_front());
                sent_cnt++;
                if (request_q.size() > 0) send_wait = request_q[0].gap;
            end
            if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (request_q.size() > 0 &&
                         (!request_q[0].drain || pending_results.size() == 0)) begin
                s_tvalid <= 1'b1;
                s_tdata <= {request_q[0].value, request_q[0].position};
                s_tuser <= request_q[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
            hold_cnt = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("Result transaction arrived with no request outstanding");
                    error_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                    check_field("read_value", want.read_value, m_tdata[33:2]);
                    check_field("found_position", 32'(want.found_position),
                                32'(m_tdata[41:34]));
                    check_field("list_length", 32'(want.list_length), 32'(m_tdata[49:42]));
                end
                results_seen++;
                recv_wait = ((results_seen / 45) % 3 == 2) ? 0 : $urandom_range(0, 11);
                if (results_seen == 140) hold_cnt = 200;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Empty-list checks, range errors, signed extremes and duplicate locate.
        queue_request(olist_pkg::KIND_READ, 1, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 1, 32'h0);
        queue_request(olist_pkg::KIND_LOCATE, 0, 32'h0);
        queue_request(olist_pkg::KIND_INSERT, 0, 32'h1);
        queue_request(olist_pkg::KIND_INSERT, 2, 32'h2);
        queue_request(olist_pkg::KIND_INSERT, 1, 32'h7FFF_FFFF);
        queue_request(olist_pkg::KIND_INSERT, 2, 32'h8000_0000);
        queue_request(olist_pkg::KIND_INSERT, 1, 32'hFFFF_FFFF);
        queue_request(olist_pkg::KIND_INSERT, 4, 32'h0000_0000);
        queue_request(olist_pkg::KIND_INSERT, 2, 32'h1234_5678);
        queue_request(olist_pkg::KIND_READ, 1, 32'h0);
        queue_request(olist_pkg::KIND_READ, 5, 32'hFFFF_FFFF);
        queue_request(olist_pkg::KIND_READ, 6, 32'h0);
        queue_request(olist_pkg::KIND_READ, 0, 32'h0);
        queue_request(olist_pkg::KIND_READ, 255, 32'h0);
        queue_request(olist_pkg::KIND_LOCATE, 1, 32'h8000_0000);
        queue_request(olist_pkg::KIND_LOCATE, 255, 32'h0000_0055);
        queue_request(olist_pkg::KIND_INSERT, 6, 32'h1234_5678);
        queue_request(olist_pkg::KIND_LOCATE, 0, 32'h1234_5678);
        queue_request(olist_pkg::KIND_DELETE, 7, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 0, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 255, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 6, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 1, 32'h0);
        queue_request(olist_pkg::KIND_DELETE, 3, 32'h0);

        // Fill past capacity, drain most of it, then a balanced mix.
        for (int i = 0; i < 250; i++) random_request(80, 5, i == 0);
        for (int i = 0; i < 150; i++) random_request(5, 70, i == 0);
        for (int i = 0; i < 200; i++) random_request(35, 30, i == 0);
        total_items = request_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (sent_cnt == total_items && pending_results.size() == 0);
        repeat (20) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
